/* rtl/size_class_bin_allocator_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the size-class bin allocator
// Shared helpers for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_BIN_ALLOCATOR_TOP_DEFINES_SVH
`define SIZE_CLASS_BIN_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SCBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SCBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/scba_pkg.sv */
// ----------------------------------------------------------------------------
// scba_pkg
// Types, codes and size-class tables shared by the bin allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

  // Fixed geometry of the heap.
  localparam int PAGE_BYTES    = 4096;
  localparam int GRANULE_BYTES = 16;
  localparam int NUM_BINS      = 28;
  localparam int OFF_W         = 21;
  localparam int ES_W          = 23;
  localparam int SPAN_W        = 11;
  localparam int CNT_W         = 17;
  localparam int RAW_W         = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  // First bin whose element size reaches a whole page.
  localparam logic [4:0] PAGE_BIN = 5'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_PAGES = 1'd1;

  // Request function codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TOO_LARGE,
    ST_EXHAUSTED,
    ST_BAD_FREE,
    ST_MISMATCH,
    ST_NULL_FREE
  } status_t;

  typedef struct packed {
    logic        func;
    logic [23:0] alloc_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic [2:0]  status;
    logic [4:0]  bin_used;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_POP_RD,
    S_POP_WR,
    S_REFILL,
    S_CARVE,
    S_PC_CHK,
    S_PC_RD,
    S_PC_WR,
    S_FREE_CHK,
    S_FENT,
    S_FALIGN,
    S_SPAN_CHK,
    S_SPAN_EV,
    S_FPUSH,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DECODE,
    OP_POP_RD,
    OP_POP_WR,
    OP_REFILL_PG,
    OP_REFILL_FIN,
    OP_CARVE,
    OP_PT_RD,
    OP_PC_WR,
    OP_FENT,
    OP_CLR_I,
    OP_INC_I,
    OP_FPUSH,
    OP_RESULT
  } dp_op_t;

  // Controller to datapath.
  typedef struct packed {
    dp_op_t  op;
    status_t code;
    logic    bin_ok;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic func_free;
    logic fit_ok;
    logic have_free;
    logic raw_empty;
    logic grow_fail;
    logic rf_go;
    logic pc_go;
    logic i_lt_n;
    logic span_oob;
    logic faddr_null;
    logic range_bad;
    logic q_inuse;
    logic q_bin_bad;
    logic q_bin_ne;
    logic misalign;
    logic res_free;
  } sts_t;

  // Element size of each bin in bytes.
  function automatic logic [ES_W-1:0] elem_size(input logic [4:0] b);
    logic [ES_W-1:0] es;
    case (b)
      5'd0:    es = 23'h000010;
      5'd1:    es = 23'h000020;
      5'd2:    es = 23'h000040;
      5'd3:    es = 23'h000080;
      5'd4:    es = 23'h000100;
      5'd5:    es = 23'h000200;
      5'd6:    es = 23'h000400;
      5'd7:    es = 23'h000800;
      5'd8:    es = 23'h001000;
      5'd9:    es = 23'h002000;
      5'd10:   es = 23'h003000;
      5'd11:   es = 23'h004000;
      5'd12:   es = 23'h005000;
      5'd13:   es = 23'h006000;
      5'd14:   es = 23'h007000;
      5'd15:   es = 23'h008000;
      5'd16:   es = 23'h009000;
      5'd17:   es = 23'h00a000;
      5'd18:   es = 23'h00b000;
      5'd19:   es = 23'h00c000;
      5'd20:   es = 23'h00d000;
      5'd21:   es = 23'h00e000;
      5'd22:   es = 23'h00f000;
      5'd23:   es = 23'h010000;
      5'd24:   es = 23'h100000;
      5'd25:   es = 23'h200000;
      5'd26:   es = 23'h300000;
      5'd27:   es = 23'h400000;
      default: es = '0;
    endcase
    return es;
  endfunction

  // Pages spanned by one element, at least one.
  function automatic logic [SPAN_W-1:0] span_pages(input logic [4:0] b);
    logic [ES_W-1:0] es;
    es = elem_size(b);
    return (b < PAGE_BIN) ? SPAN_W'(1) : es[ES_W-1:12];
  endfunction

  // Elements carved from one refill, also the initial per-page free count.
  function automatic logic [RAW_W-1:0] per_grow(input logic [4:0] b);
    return (b < PAGE_BIN) ? (RAW_W'(256) >> b) : RAW_W'(1);
  endfunction

  // First bin that holds the size; the top bit flags a hit.
  function automatic logic [5:0] first_fit(input logic [23:0] size);
    logic [5:0] r;
    r = '0;
    for (int b = NUM_BINS - 1; b >= 0; b--) begin
      if (size <= 24'(elem_size(5'(b)))) begin
        r = {1'b1, 5'(b)};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/scba_ctrl.sv */
// ----------------------------------------------------------------------------
// scba_ctrl
// Sequencer for the bin allocator: walks one request through its steps and
// issues at most one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  scba_pkg::sts_t sts,
  output scba_pkg::cmd_t cmd
);
  import scba_pkg::*;

  state_t  state, state_next;
  status_t code, code_next;
  logic    bin_ok, bin_ok_next;

  // State and pending result code.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      code   <= ST_OK;
      bin_ok <= 1'b0;
    end else begin
      state  <= state_next;
      code   <= code_next;
      bin_ok <= bin_ok_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    code_next   = code;
    bin_ok_next = bin_ok;
    cmd.op      = OP_NONE;
    cmd.code    = code;
    cmd.bin_ok  = bin_ok;
    req_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op     = OP_DECODE;
        state_next = S_ALLOC;
      end
      S_ALLOC: begin
        if (sts.func_free) begin
          state_next = S_FREE_CHK;
        end else if (!sts.fit_ok) begin
          code_next   = ST_TOO_LARGE;
          bin_ok_next = 1'b0;
          state_next  = S_FINISH;
        end else if (sts.have_free) begin
          state_next = S_POP_RD;
        end else if (sts.raw_empty) begin
          if (sts.grow_fail) begin
            code_next   = ST_EXHAUSTED;
            bin_ok_next = 1'b1;
            state_next  = S_FINISH;
          end else begin
            state_next = S_REFILL;
          end
        end else begin
          state_next = S_CARVE;
        end
      end
      S_POP_RD: begin
        cmd.op     = OP_POP_RD;
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.op     = OP_POP_WR;
        state_next = S_PC_CHK;
      end
      S_REFILL: begin
        if (sts.rf_go) begin
          cmd.op = OP_REFILL_PG;
        end else begin
          cmd.op     = OP_REFILL_FIN;
          state_next = S_CARVE;
        end
      end
      S_CARVE: begin
        cmd.op     = OP_CARVE;
        state_next = S_PC_CHK;
      end
      // Page free-count update loop, shared by both functions.
      S_PC_CHK: begin
        if (sts.pc_go) begin
          state_next = S_PC_RD;
        end else if (sts.func_free) begin
          state_next = S_FPUSH;
        end else begin
          code_next   = ST_OK;
          bin_ok_next = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_PC_RD: begin
        cmd.op     = OP_PT_RD;
        state_next = S_PC_WR;
      end
      S_PC_WR: begin
        cmd.op     = OP_PC_WR;
        state_next = S_PC_CHK;
      end
      S_FREE_CHK: begin
        bin_ok_next = 1'b0;
        if (sts.faddr_null) begin
          code_next  = ST_NULL_FREE;
          state_next = S_FINISH;
        end else if (sts.range_bad) begin
          code_next  = ST_BAD_FREE;
          state_next = S_FINISH;
        end else begin
          cmd.op     = OP_PT_RD;
          state_next = S_FENT;
        end
      end
      S_FENT: begin
        cmd.op = OP_FENT;
        if (!sts.q_inuse) begin
          code_next  = ST_BAD_FREE;
          state_next = S_FINISH;
        end else if (sts.q_bin_bad) begin
          code_next  = ST_MISMATCH;
          state_next = S_FINISH;
        end else begin
          state_next = S_FALIGN;
        end
      end
      S_FALIGN: begin
        if (sts.misalign) begin
          code_next   = ST_MISMATCH;
          bin_ok_next = 1'b1;
          state_next  = S_FINISH;
        end else begin
          state_next = S_SPAN_CHK;
        end
      end
      // Every page of the element must be in range and carry the same bin.
      S_SPAN_CHK: begin
        if (!sts.i_lt_n) begin
          cmd.op     = OP_CLR_I;
          state_next = S_PC_CHK;
        end else if (sts.span_oob) begin
          code_next   = ST_MISMATCH;
          bin_ok_next = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.op     = OP_PT_RD;
          state_next = S_SPAN_EV;
        end
      end
      S_SPAN_EV: begin
        if (sts.q_bin_ne) begin
          code_next   = ST_MISMATCH;
          bin_ok_next = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.op     = OP_INC_I;
          state_next = S_SPAN_CHK;
        end
      end
      S_FPUSH: begin
        cmd.op      = OP_FPUSH;
        code_next   = ST_OK;
        bin_ok_next = 1'b1;
        state_next  = S_FINISH;
      end
      // Wait until the result register can take a new transfer.
      S_FINISH: begin
        if (sts.res_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/scba_dp.sv */
// ----------------------------------------------------------------------------
// scba_dp
// Allocator datapath: configuration, bin state, page table, link memory and
// the result register. Executes one controller command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_dp #(
  parameter int HEAP_PAGES = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [scba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scba_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  scba_pkg::req_t                     req,
  input  scba_pkg::cmd_t                     cmd,
  output scba_pkg::sts_t                     sts,
  input  logic                               rsp_stall,
  output logic                               rsp_valid,
  output scba_pkg::rsp_t                     rsp
);
  import scba_pkg::*;

  localparam int PG_W       = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
  localparam int LINK_DEPTH = HEAP_PAGES * (PAGE_BYTES / GRANULE_BYTES);
  localparam int LI_W       = $clog2(LINK_DEPTH);

  // Configuration.
  logic [31:0] base_addr;
  logic [8:0]  heap_pages;

  // Request and working registers.
  logic              func;
  logic [23:0]       size;
  logic [31:0]       faddr;
  logic [4:0]        bin;
  logic              fit_ok;
  logic [31:0]       off32;
  logic [OFF_W-1:0]  off;
  logic [SPAN_W-1:0] i;
  logic [OFF_W-1:0]  bump;
  logic [PG_W-1:0]   clr_cnt;
  logic              li_ok_q;

  // Per-bin state.
  logic [OFF_W-1:0] head      [NUM_BINS];
  logic [CNT_W-1:0] free_cnt  [NUM_BINS];
  logic [CNT_W-1:0] alloc_cnt [NUM_BINS];
  logic [OFF_W-1:0] raw_next  [NUM_BINS];
  logic [RAW_W-1:0] raw_left  [NUM_BINS];

  // Page table and free-list link memory.
  logic [15:0]      pt [HEAP_PAGES];
  logic [15:0]      pt_q;
  logic [OFF_W-1:0] link [LINK_DEPTH];
  logic [OFF_W-1:0] link_q;

  // Derived values.
  logic [8:0]        pages_eff;
  logic [OFF_W-1:0]  limit;
  logic [ES_W-1:0]   es;
  logic [ES_W-1:0]   es_m1;
  logic [SPAN_W-1:0] n;
  logic [ES_W-1:0]   grow;
  logic [11:0]       pg_off;
  logic [11:0]       pg_bump;
  logic [OFF_W-5:0]  li_head;
  logic [OFF_W-5:0]  li_off;
  logic              li_head_ok;
  logic              li_off_ok;
  logic [5:0]        fit;
  logic [8:0]        fc_upd;
  logic              pt_we;
  logic [PG_W-1:0]   pt_waddr;
  logic [15:0]       pt_wdata;

  always_comb begin
    if (32'(heap_pages) > HEAP_PAGES) begin
      pages_eff = 9'(HEAP_PAGES);
    end else begin
      pages_eff = heap_pages;
    end
  end

  assign limit      = {pages_eff, 12'd0};
  assign es         = elem_size(bin);
  assign es_m1      = es - 23'd1;
  assign n          = span_pages(bin);
  assign grow       = (bin < PAGE_BIN) ? ES_W'(PAGE_BYTES) : es;
  assign pg_off     = {3'd0, off[OFF_W-1:12]} + {1'b0, i};
  assign pg_bump    = {3'd0, bump[OFF_W-1:12]} + {1'b0, i};
  assign li_head    = head[bin][OFF_W-1:4];
  assign li_off     = off[OFF_W-1:4];
  assign li_head_ok = 32'(li_head) < LINK_DEPTH;
  assign li_off_ok  = 32'(li_off) < LINK_DEPTH;
  assign fit        = first_fit(size);
  assign fc_upd     = pt_q[13:5] + ((func == FUNC_FREE) ? 9'd1 : 9'h1FF);

  // Status to the controller.
  always_comb begin
    sts.clr_last   = 32'(clr_cnt) == HEAP_PAGES - 1;
    sts.func_free  = func == FUNC_FREE;
    sts.fit_ok     = fit_ok;
    sts.have_free  = free_cnt[bin] != '0;
    sts.raw_empty  = raw_left[bin] == '0;
    sts.grow_fail  = ({3'd0, bump} + {1'b0, grow}) > {3'd0, limit};
    sts.i_lt_n     = i < n;
    sts.rf_go      = (i < n) && (32'(pg_bump) < HEAP_PAGES);
    sts.pc_go      = (i < n) && (32'(pg_off) < HEAP_PAGES);
    sts.span_oob   = pg_off >= {3'd0, pages_eff};
    sts.faddr_null = faddr == '0;
    sts.range_bad  = off32 >= {11'd0, limit};
    sts.q_inuse    = pt_q[15];
    sts.q_bin_bad  = 32'(pt_q[4:0]) >= NUM_BINS;
    sts.q_bin_ne   = pt_q[4:0] != bin;
    sts.misalign   = (bin <= PAGE_BIN) && (({2'd0, off} & es_m1) != '0);
    sts.res_free   = !rsp_valid || !rsp_stall;
  end

  // Page table write port selection.
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = PG_W'(pg_off);
    pt_wdata = {pt_q[15:14], fc_upd, pt_q[4:0]};
    case (cmd.op)
      OP_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_cnt;
        pt_wdata = '0;
      end
      OP_REFILL_PG: begin
        pt_we    = 32'(pg_bump) < HEAP_PAGES;
        pt_waddr = PG_W'(pg_bump);
        pt_wdata = {1'b1, 1'b0, per_grow(bin), bin};
      end
      OP_PC_WR: begin
        pt_we = 32'(pg_off) < HEAP_PAGES;
      end
      default: begin
        pt_we = 1'b0;
      end
    endcase
  end

  // Page table memory with registered read.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt[pt_waddr] <= pt_wdata;
    end
    if (cmd.op == OP_PT_RD) begin
      pt_q <= pt[PG_W'(pg_off)];
    end
  end

  // Link memory: a push writes the old head, a pop reads the next element.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FPUSH && li_off_ok) begin
      link[LI_W'(li_off)] <= head[bin];
    end
    if (cmd.op == OP_POP_RD) begin
      link_q <= link[LI_W'(li_head)];
    end
  end

  // Request payload and working offsets.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        func  <= req.func;
        size  <= req.alloc_size;
        faddr <= req.free_address;
      end
      OP_DECODE: begin
        fit_ok <= fit[5];
        bin    <= fit[4:0];
        off32  <= faddr - base_addr;
        off    <= OFF_W'(faddr - base_addr);
      end
      OP_POP_RD: begin
        off     <= head[bin];
        li_ok_q <= li_head_ok;
      end
      OP_CARVE: begin
        off <= raw_next[bin];
      end
      OP_FENT: begin
        if (32'(pt_q[4:0]) < NUM_BINS) begin
          bin <= pt_q[4:0];
        end
      end
      OP_RESULT: begin
        rsp.address  <= (cmd.code == ST_OK && func == FUNC_ALLOC) ?
                        base_addr + 32'(off) : '0;
        rsp.status   <= cmd.code;
        rsp.bin_used <= cmd.bin_ok ? bin : '0;
      end
      default: begin
      end
    endcase
  end

  // Configuration, bin state, counters and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr  <= '0;
      heap_pages <= 9'd256;
      bump       <= '0;
      i          <= '0;
      clr_cnt    <= '0;
      rsp_valid  <= 1'b0;
      for (int b = 0; b < NUM_BINS; b++) begin
        head[b]      <= '0;
        free_cnt[b]  <= '0;
        alloc_cnt[b] <= '0;
        raw_next[b]  <= '0;
        raw_left[b]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ADDR:  base_addr  <= cfg_data;
          REG_HEAP_PAGES: heap_pages <= cfg_data[8:0];
          default: begin
          end
        endcase
      end
      // The result register fills on a result step and empties on a transfer.
      rsp_valid <= (cmd.op == OP_RESULT) || (rsp_valid && rsp_stall);
      case (cmd.op)
        OP_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        OP_DECODE, OP_CLR_I: begin
          i <= '0;
        end
        OP_POP_WR: begin
          head[bin]      <= li_ok_q ? link_q : '0;
          free_cnt[bin]  <= free_cnt[bin] - 1'b1;
          alloc_cnt[bin] <= alloc_cnt[bin] + 1'b1;
          i              <= '0;
        end
        OP_REFILL_PG, OP_PC_WR, OP_INC_I: begin
          i <= i + 1'b1;
        end
        OP_REFILL_FIN: begin
          raw_next[bin] <= bump;
          raw_left[bin] <= per_grow(bin);
          bump          <= bump + OFF_W'(grow);
          i             <= '0;
        end
        OP_CARVE: begin
          raw_left[bin]  <= raw_left[bin] - 1'b1;
          raw_next[bin]  <= raw_next[bin] + OFF_W'(es);
          alloc_cnt[bin] <= alloc_cnt[bin] + 1'b1;
          i              <= '0;
        end
        OP_FPUSH: begin
          head[bin]      <= off;
          alloc_cnt[bin] <= alloc_cnt[bin] - 1'b1;
          free_cnt[bin]  <= free_cnt[bin] + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/size_class_bin_allocator_top.sv */
// Throughput: one request at a time; the next transfer is taken the cycle after the
// result is loaded, and a result still waiting holds the next one in its last step.
// Reset (synchronous, active high) clears the state, then clears every page table entry.
// ----------------------------------------------------------------------------
// size_class_bin_allocator_top
// Size-class heap allocator with 28 fixed bins, LIFO free lists, raw runs
// refilled from a page bump pointer and a per-page bookkeeping table.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_bin_allocator_top #(
  parameter int HEAP_PAGES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  scba_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output scba_pkg::rsp_t                  rsp,
  input  logic                            cfg_we,
  input  logic [scba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scba_pkg::*;

  `include "size_class_bin_allocator_top_defines.svh"

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  scba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath and storage.
  scba_dp #(
    .HEAP_PAGES (HEAP_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // Once a request is taken, the channel stalls while it is in work.
  `SCBA_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted while busy")
  // No request is taken while the page table is being cleared.
  `SCBA_ASSERT_IMP(a_no_accept_clear, cmd.op == OP_CLEAR, req_stall, "accept during clear")
  // Only a successful result carries a nonzero address.
  `SCBA_ASSERT_IMP(a_addr_on_ok, rsp_valid && rsp.status != ST_OK, rsp.address == '0, "error addr")

endmodule

`default_nettype wire

/* tb/sv/tb_size_class_bin_allocator_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the size-class bin allocator
// Drives allocate and free requests through the request channel, predicts
// each response with a behavioral allocator kept in step with the block, and
// compares every response field by field. Heap base and page count change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_size_class_bin_allocator_top;
  import scba_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  // Element size of each size class.
  localparam int unsigned BIN_BYTES [28] = '{
    32'h10, 32'h20, 32'h40, 32'h80, 32'h100, 32'h200, 32'h400, 32'h800,
    32'h1000, 32'h2000, 32'h3000, 32'h4000, 32'h5000, 32'h6000, 32'h7000,
    32'h8000, 32'h9000, 32'ha000, 32'hb000, 32'hc000, 32'hd000, 32'he000,
    32'hf000, 32'h10000, 32'h100000, 32'h200000, 32'h300000, 32'h400000
  };

  typedef struct {
    req_t r;
    bit   hold;
  } pend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  size_class_bin_allocator_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the allocator state.
  logic [31:0] m_base;
  logic [8:0]  m_pages;
  logic [20:0] m_bump;
  logic [20:0] m_head [28];
  logic [16:0] m_fcnt [28];
  logic [16:0] m_acnt [28];
  logic [20:0] m_rnext [28];
  logic [8:0]  m_rleft [28];
  logic [15:0] m_ptab [256];
  logic [20:0] m_link [65536];
  bit          live_map [65536];
  int unsigned live_q [$];

  pend_t pend_q [$];
  rsp_t  exp_rsp_q [$];
  int    n_total = 0;
  int    n_acc = 0;
  int    n_recv = 0;
  int    n_err = 0;
  int    cycles = 0;
  int    snd_idle = 0;
  int    rcv_idle = 0;
  bit    req_took = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic int unsigned eff_pages();
    return (m_pages > 9'd256) ? 256 : int'(m_pages);
  endfunction

  function automatic int unsigned bin_span(input int unsigned b);
    return (BIN_BYTES[b] < 4096) ? 1 : BIN_BYTES[b] / 4096;
  endfunction

  // Per-page free count, wrapping at nine bits.
  function automatic void page_add(input int unsigned pg, input logic [8:0] delta);
    if (pg < 256) m_ptab[pg][13:5] = m_ptab[pg][13:5] + delta;
  endfunction

  function automatic rsp_t alloc_result(input logic [23:0] size);
    rsp_t r;
    int unsigned b, off, es, grow, lim, fc, i;
    r = '0;
    b = 28;
    for (i = 0; i < 28; i++) begin
      if (b == 28 && size <= BIN_BYTES[i]) b = i;
    end
    if (b == 28) begin
      r.status = ST_TOO_LARGE;
      return r;
    end
    es = BIN_BYTES[b];
    if (m_fcnt[b] != 0) begin
      // Pop the free list.
      off = m_head[b];
      m_head[b] = m_link[off >> 4];
      m_fcnt[b] = m_fcnt[b] - 1'b1;
    end else begin
      if (m_rleft[b] == 0) begin
        // Refill the run from the bump pointer.
        grow = (es < 4096) ? 4096 : es;
        lim = eff_pages() * 4096;
        fc = (es < 4096) ? 4096 / es : 1;
        if (m_bump > lim || grow > lim - m_bump) begin
          r.status = ST_EXHAUSTED;
          r.bin_used = b[4:0];
          return r;
        end
        for (i = 0; i < grow / 4096; i++) begin
          if (m_bump / 4096 + i < 256)
            m_ptab[m_bump / 4096 + i] = {1'b1, 1'b0, fc[8:0], b[4:0]};
        end
        m_rnext[b] = m_bump;
        m_rleft[b] = 9'(grow / es);
        m_bump = m_bump + 21'(grow);
      end
      m_rleft[b] = m_rleft[b] - 1'b1;
      off = m_rnext[b];
      m_rnext[b] = m_rnext[b] + 21'(es);
    end
    m_acnt[b] = m_acnt[b] + 1'b1;
    for (i = 0; i < bin_span(b); i++) page_add(off / 4096 + i, 9'h1FF);
    r.address = m_base + off;
    r.status = ST_OK;
    r.bin_used = b[4:0];
    return r;
  endfunction

  // With commit clear this only reports what a free would return.
  function automatic rsp_t free_result(input logic [31:0] addr, input bit commit);
    rsp_t r;
    logic [31:0] off;
    int unsigned pg, b, i;
    logic [15:0] e;
    r = '0;
    if (addr == 0) begin
      r.status = ST_NULL_FREE;
      return r;
    end
    off = addr - m_base;
    if (off >= eff_pages() * 4096) begin
      r.status = ST_BAD_FREE;
      return r;
    end
    pg = off >> 12;
    e = m_ptab[pg];
    if (!e[15]) begin
      r.status = ST_BAD_FREE;
      return r;
    end
    b = e[4:0];
    if (b >= 28) begin
      r.status = ST_MISMATCH;
      return r;
    end
    r.bin_used = b[4:0];
    if (BIN_BYTES[b] <= 4096 && (off % BIN_BYTES[b]) != 0) begin
      r.status = ST_MISMATCH;
      return r;
    end
    for (i = 0; i < bin_span(b); i++) begin
      if (pg + i >= eff_pages() || m_ptab[pg + i][4:0] != b[4:0]) begin
        r.status = ST_MISMATCH;
        return r;
      end
    end
    r.status = ST_OK;
    if (commit) begin
      for (i = 0; i < bin_span(b); i++) page_add(pg + i, 9'd1);
      m_link[off >> 4] = m_head[b];
      m_head[b] = off[20:0];
      m_acnt[b] = m_acnt[b] - 1'b1;
      m_fcnt[b] = m_fcnt[b] + 1'b1;
    end
    return r;
  endfunction

  task automatic push_req(input req_t r, input rsp_t x, input bit hold);
    pend_t p;
    p.r = r;
    p.hold = hold;
    pend_q.push_back(p);
    exp_rsp_q.push_back(x);
    n_total++;
  endtask

  task automatic add_alloc(input logic [23:0] size, input bit hold = 1'b0);
    req_t r;
    rsp_t x;
    int unsigned off;
    r.func = FUNC_ALLOC;
    r.alloc_size = size;
    r.free_address = $urandom;
    x = alloc_result(size);
    if (x.status == ST_OK) begin
      off = x.address - m_base;
      live_q.push_back(off);
      live_map[off >> 4] = 1'b1;
    end
    push_req(r, x, hold);
  endtask

  // A free that would succeed on an element not handed out becomes a null
  // free, so the free lists never hold an element twice.
  task automatic add_free(input logic [31:0] addr, input bit hold = 1'b0);
    req_t r;
    rsp_t x;
    logic [31:0] off;
    x = free_result(addr, 1'b0);
    off = addr - m_base;
    if (x.status == ST_OK && !live_map[off >> 4]) addr = '0;
    r.func = FUNC_FREE;
    r.alloc_size = $urandom;
    r.free_address = addr;
    x = free_result(addr, 1'b1);
    if (x.status == ST_OK) begin
      live_map[off >> 4] = 1'b0;
      for (int i = 0; i < live_q.size(); i++) begin
        if (live_q[i] == off) begin
          live_q.delete(i);
          break;
        end
      end
    end
    push_req(r, x, hold);
  endtask

  function automatic logic [23:0] pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 24'($urandom_range(2048, 0));
    if (p < 75) return 24'($urandom_range(8192, 2049));
    if (p < 88) return 24'($urandom_range(65536, 8193));
    if (p < 94) return 24'($urandom_range(32'h400000, 65537));
    return 24'($urandom);
  endfunction

  // Mostly allocations and frees of live elements, with some noise.
  task automatic random_items(input int count);
    int unsigned p, k;
    logic [31:0] addr;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(99);
      if (p < 45 && live_q.size() > 0) begin
        k = $urandom_range(live_q.size() - 1);
        addr = m_base + live_q[k];
        if ($urandom_range(9) == 0) addr = addr + $urandom_range(15, 1);
        add_free(addr, i == count / 2);
      end else if (p < 53) begin
        if ($urandom_range(1)) addr = $urandom;
        else addr = m_base + ($urandom_range(32'h10FFFF) & 32'hFFFFFFF0);
        add_free(addr, i == count / 2);
      end else begin
        add_alloc(pick_size(), i == count / 2);
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BASE_ADDR) m_base = val;
    else m_pages = val[8:0];
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || n_recv != n_total || req_valid) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Request driver: a new transfer is offered only after the last one left.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (pend_q.size() != 0 && !(pend_q[0].hold && n_recv != n_acc) &&
          $urandom_range(99) >= snd_idle) begin
        req <= pend_q[0].r;
        req_valid <= 1'b1;
        pend_q.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response stall pattern.
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < rcv_idle);
  end

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h actual %h", $time, name, e, a);
      n_err++;
    end
  endtask

  // Monitor: count request transfers and check each response transfer.
  always @(posedge clk) begin
    rsp_t x;
    req_took <= req_valid && !req_stall;
    if (req_valid && !req_stall) n_acc <= n_acc + 1;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (exp_rsp_q.size() == 0) begin
        $display("%0t: response with nothing expected, actual %h", $time, rsp);
        n_err++;
      end else begin
        x = exp_rsp_q.pop_front();
        check_field("address", x.address, rsp.address);
        check_field("status", 32'(x.status), 32'(rsp.status));
        check_field("bin_used", 32'(x.bin_used), 32'(rsp.bin_used));
      end
      n_recv <= n_recv + 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    m_base = '0;
    m_pages = 9'd256;
    m_bump = '0;
    for (int i = 0; i < 28; i++) begin
      m_head[i] = '0; m_fcnt[i] = '0; m_acnt[i] = '0;
      m_rnext[i] = '0; m_rleft[i] = '0;
    end
    for (int i = 0; i < 256; i++) m_ptab[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part.
    snd_idle = 23;
    rcv_idle = 65;
    cfg_write(REG_BASE_ADDR, 32'h8000_0000);
    cfg_write(REG_HEAP_PAGES, 32'd256);
    add_alloc(24'd0);
    add_alloc(24'd16);
    add_alloc(24'd17);
    add_alloc(24'd2048);
    add_alloc(24'd4096);
    add_alloc(24'h10000);
    add_alloc(24'h400000);
    add_alloc(24'h400001);
    add_alloc(24'hFFFFFF);
    add_alloc(24'h200000);
    add_free(32'd0);
    add_free(32'hFFFF_FFFF);
    add_free(32'h8000_0018);
    add_free(32'h8000_2008);
    add_free(32'h8000_0010);
    add_alloc(24'd20);
    add_free(32'h8000_0000);
    add_free(32'h8000_0000);
    add_alloc(24'd1);
    add_free(32'h8000_3000, 1'b1);
    add_alloc(24'h1000);
    random_items(460);
    wait_idle();

    snd_idle = 65;
    rcv_idle = 23;
    cfg_write(REG_BASE_ADDR, 32'hFFFF_F000);
    cfg_write(REG_HEAP_PAGES, 32'd173);
    random_items(460);
    wait_idle();
    cfg_write(REG_HEAP_PAGES, 32'd1);
    random_items(60);
    wait_idle();

    snd_idle = 0;
    rcv_idle = 0;
    cfg_write(REG_BASE_ADDR, 32'hFFFF_FFFF);
    cfg_write(REG_HEAP_PAGES, 32'd256);
    random_items(450);
    wait_idle();

    if (n_err == 0 && exp_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_ctrl.sv
rtl/scba_dp.sv
rtl/size_class_bin_allocator_top.sv
tb/sv/tb_size_class_bin_allocator_top.sv
